FILE: rtl/smd_pkg.sv
// Shared types and constants for the stack with middle delete block.
package smd_pkg;

  localparam int unsigned DATA_W      = 32;
  localparam int unsigned MODE_W      = 2;
  localparam int unsigned STATUS_W    = 2;
  localparam int unsigned TOTAL_W     = 5;
  localparam int unsigned DEPTH_DFLT  = 16;

  typedef enum logic [MODE_W-1:0] {
    MODE_PUSH = 2'd0,
    MODE_POP  = 2'd1,
    MODE_DEL  = 2'd2,
    MODE_NONE = 2'd3
  } mode_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  // Command broadcast to every cell of the chain.
  typedef enum logic [1:0] {
    CMD_HOLD = 2'd0,
    CMD_PUSH = 2'd1,
    CMD_POP  = 2'd2,
    CMD_DEL  = 2'd3
  } cmd_e;

endpackage

FILE: rtl/smd_cell.sv
// One storage cell of the stack chain, holding the entry at a fixed depth from the top.
module smd_cell #(
  parameter int unsigned IDX_W = 4,
  parameter int unsigned IDX   = 0
) (
  input  logic                        clk_i,
  input  smd_pkg::cmd_e               cmd_i,
  input  logic [IDX_W-1:0]            split_i,
  input  logic [smd_pkg::DATA_W-1:0]  upper_i,
  input  logic [smd_pkg::DATA_W-1:0]  lower_i,
  input  logic [IDX_W-1:0]            sel_idx_i,
  output logic [smd_pkg::DATA_W-1:0]  data_o,
  output logic [smd_pkg::DATA_W-1:0]  pick_o
);
  import smd_pkg::*;

  localparam logic [IDX_W-1:0] MyIdx = IDX_W'(IDX);

  logic [DATA_W-1:0] data_q, data_d;

  always_comb begin
    case (cmd_i)
      CMD_PUSH: data_d = upper_i;
      CMD_POP:  data_d = lower_i;
      // Cells at or below the middle close the gap; those above keep their entry.
      CMD_DEL:  data_d = (MyIdx >= split_i) ? lower_i : data_q;
      default:  data_d = data_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;
  assign pick_o = (sel_idx_i == MyIdx) ? data_q : '0;

endmodule

FILE: rtl/stack_with_middle_delete_unit.sv
// Top level of the bounded stack with pop, push and delete of the middle entry.
//
// The stack is a row of STACK_DEPTH cells, cell 0 holding the top entry. A push
// moves every entry one cell deeper, a pop moves every entry one cell up, and a
// delete of the middle entry moves up only the cells from the middle (position
// floor(n/2) from the top) downwards, so the entries above it stay where they are.
// An accepted word is handled in the cycle of acceptance, where the cells shift and
// the shared one-hot read port fetches the removed entry, and then in the middle-read
// state, where the same read port fetches the new middle entry and the result word
// is loaded into the output register once it is free or emptied. The block takes a
// new word only when idle, after the last word's result is loaded; a waiting result
// does not stop the next word being accepted, it only holds that word's middle
// read. Stored entries need no clearing after reset: only entries below the count
// are ever read. A refused push (full) or pop or delete (empty) leaves the stack
// as it was, and the unused mode code is reported as done with no change.
module stack_with_middle_delete_unit #(
  parameter int unsigned STACK_DEPTH = smd_pkg::DEPTH_DFLT
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [smd_pkg::MODE_W-1:0]          mode_i,
  input  logic signed [smd_pkg::DATA_W-1:0]   push_value_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [smd_pkg::DATA_W-1:0]   removed_value_o,
  output logic signed [smd_pkg::DATA_W-1:0]   middle_value_o,
  output logic                                middle_valid_o,
  output logic [smd_pkg::TOTAL_W-1:0]         entry_total_o,
  output logic [smd_pkg::STATUS_W-1:0]        status_o
);
  import smd_pkg::*;

  localparam int unsigned IDX_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(STACK_DEPTH + 1);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_MID  = 2'b10
  } state_e;

  state_e            state_q, state_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic              in_fire;
  logic              load_out;

  // Result of the acceptance cycle, waiting for the middle read.
  logic [DATA_W-1:0]   removed_pend_q, removed_pend_d;
  status_e             status_pend_q, status_pend_d;

  // Output register.
  logic                out_valid_q, out_valid_d;
  logic [DATA_W-1:0]   removed_q, middle_q;
  logic                mvalid_q;
  logic [TOTAL_W-1:0]  total_q;
  status_e             status_q;

  cmd_e              cmd;
  logic [IDX_W-1:0]  split_idx;
  logic [IDX_W-1:0]  sel_idx;
  logic              take_removed;
  logic [DATA_W-1:0] picked;

  logic [DATA_W-1:0] cell_data [STACK_DEPTH];
  logic [DATA_W-1:0] cell_pick [STACK_DEPTH];

  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign split_idx  = IDX_W'(count_q >> 1);

  // Decode the accepted word into a cell command, a status and the new count.
  always_comb begin
    cmd           = CMD_HOLD;
    status_pend_d = status_pend_q;
    count_d       = count_q;
    take_removed  = 1'b0;
    sel_idx       = split_idx;
    if (in_fire) begin
      status_pend_d = ST_DONE;
      case (mode_i)
        MODE_PUSH: begin
          if (count_q == CNT_W'(STACK_DEPTH)) begin
            status_pend_d = ST_FULL;
          end else begin
            cmd     = CMD_PUSH;
            count_d = count_q + CNT_W'(1);
          end
        end
        MODE_POP: begin
          sel_idx = '0;
          if (count_q == '0) begin
            status_pend_d = ST_EMPTY;
          end else begin
            cmd          = CMD_POP;
            take_removed = 1'b1;
            count_d      = count_q - CNT_W'(1);
          end
        end
        MODE_DEL: begin
          if (count_q == '0) begin
            status_pend_d = ST_EMPTY;
          end else begin
            cmd          = CMD_DEL;
            take_removed = 1'b1;
            count_d      = count_q - CNT_W'(1);
          end
        end
        default: begin
          status_pend_d = ST_DONE;
        end
      endcase
    end
  end

  assign removed_pend_d = in_fire ? (take_removed ? picked : '0) : removed_pend_q;

  // The chain of cells.
  for (genvar k = 0; k < STACK_DEPTH; k++) begin : g_cell
    logic [DATA_W-1:0] upper, lower;
    if (k == 0) begin : g_top
      assign upper = push_value_i;
    end else begin : g_mid
      assign upper = cell_data[k-1];
    end
    if (k == STACK_DEPTH - 1) begin : g_bot
      assign lower = cell_data[k];
    end else begin : g_low
      assign lower = cell_data[k+1];
    end
    smd_cell #(
      .IDX_W (IDX_W),
      .IDX   (k)
    ) u_cell (
      .clk_i     (clk_i),
      .cmd_i     (cmd),
      .split_i   (split_idx),
      .upper_i   (upper),
      .lower_i   (lower),
      .sel_idx_i (sel_idx),
      .data_o    (cell_data[k]),
      .pick_o    (cell_pick[k])
    );
  end

  // One-hot read port: only the selected cell drives a non-zero word.
  always_comb begin
    picked = '0;
    for (int unsigned k = 0; k < STACK_DEPTH; k++) begin
      picked = picked | cell_pick[k];
    end
  end

  // Middle-read state: the middle read waits until the output register is free.
  assign load_out = (state_q == S_MID) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (in_fire) state_d = S_MID;
      S_MID:   if (load_out) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  logic [CNT_W+TOTAL_W-1:0] count_ext;
  assign count_ext = {{TOTAL_W{1'b0}}, count_q};

  always_ff @(posedge clk_i) begin
    removed_pend_q <= removed_pend_d;
    status_pend_q  <= status_pend_d;
    if (load_out) begin
      removed_q <= removed_pend_q;
      middle_q  <= (count_q == '0) ? '0 : picked;
      mvalid_q  <= (count_q != '0);
      total_q   <= count_ext[TOTAL_W-1:0];
      status_q  <= status_pend_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign removed_value_o = removed_q;
  assign middle_value_o  = middle_q;
  assign middle_valid_o  = mvalid_q;
  assign entry_total_o   = total_q;
  assign status_o        = status_q;

endmodule

FILE: rtl/smd_checker.sv
// Port-level assertions for the stack with middle delete block, and their bind.
module smd_checker #(
  parameter int unsigned STACK_DEPTH = smd_pkg::DEPTH_DFLT
) (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                out_valid_o,
  input logic                                out_ready_i,
  input logic signed [smd_pkg::DATA_W-1:0]   removed_value_o,
  input logic signed [smd_pkg::DATA_W-1:0]   middle_value_o,
  input logic                                middle_valid_o,
  input logic [smd_pkg::TOTAL_W-1:0]         entry_total_o,
  input logic [smd_pkg::STATUS_W-1:0]        status_o
);
  import smd_pkg::*;

  localparam bit SmallDepth = (STACK_DEPTH < 32);

  // A result word that is not taken stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result word withdrawn before it was taken");

  // A refused operation removes nothing.
  a_refused_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_EMPTY || status_o == ST_FULL) |-> removed_value_o == '0)
    else $error("refused operation reports a removed word");

  // An empty refusal always reports an empty stack.
  a_empty_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_EMPTY |-> entry_total_o == '0 && !middle_valid_o)
    else $error("empty refusal with entries held");

  // With no middle entry the middle word reads as zero.
  a_middle_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !middle_valid_o |-> middle_value_o == '0)
    else $error("middle word not zero on an empty stack");

  // The middle flag follows the count where the count field is not truncated.
  a_middle_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && SmallDepth |-> middle_valid_o == (entry_total_o != '0))
    else $error("middle flag disagrees with entry count");

endmodule

bind stack_with_middle_delete_unit smd_checker #(.STACK_DEPTH(STACK_DEPTH)) u_smd_checker (.*);
